// ===== rtl/core/tos_pkg.sv =====
// Shared types and constants for the option area search block.
package tos_pkg;

  localparam int MAX_AREA_BYTES = 1024;
  localparam int POS_W          = $clog2(MAX_AREA_BYTES);
  localparam int OFFSET_W       = 10;
  localparam int LEFT_W         = 11;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [7:0]        END_CODE    = 8'hFF;
  localparam logic [7:0]        PAD_CODE    = 8'h00;
  localparam logic [LEFT_W-1:0] LEAST_ENTRY = LEFT_W'(3);

  localparam logic REG_TARGET_CODE = 1'b0;
  localparam logic REG_MIN_LENGTH  = 1'b1;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [LEFT_W-1:0] bytes_left;
    logic              start_search;
  } in_word_t;

  typedef struct packed {
    logic                found;
    logic [7:0]          value_length;
    logic [OFFSET_W-1:0] value_offset;
  } out_word_t;

  typedef struct packed {
    logic [7:0] target_code;
    logic [7:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } scan_res_t;

endpackage

// ===== rtl/core/tos_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
module tos_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tos_pkg::PADDR_W-1:0] paddr,
  input  logic [tos_pkg::PDATA_W-1:0] pwdata,
  output logic [tos_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output tos_pkg::cfg_t               cfg
);
  import tos_pkg::*;

  logic [7:0] target_code_r;
  logic [7:0] min_length_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_code_r <= 8'd0;
      min_length_r  <= 8'd1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TARGET_CODE: target_code_r <= pwdata[7:0];
        REG_MIN_LENGTH:  min_length_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TARGET_CODE: prdata = {{(PDATA_W-8){1'b0}}, target_code_r};
      REG_MIN_LENGTH:  prdata = {{(PDATA_W-8){1'b0}}, min_length_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.target_code = target_code_r;
  assign cfg.min_length  = min_length_r;

endmodule

// ===== rtl/core/tos_scan.sv =====
// Entry walker: search state and the per-byte decision logic.
module tos_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  tos_pkg::in_word_t word,
  input  tos_pkg::cfg_t     cfg,
  output tos_pkg::scan_res_t res
);
  import tos_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CODE = 2'd1,
    PH_LEN  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt, eff_phase;
  logic             first_r, first_nxt, eff_first;
  logic [7:0]       code_r, code_nxt, eff_code;
  logic [7:0]       skip_r, skip_nxt, eff_skip;
  logic [POS_W-1:0] pos_r, pos_nxt, eff_pos, pos_adv;
  logic [LEFT_W-1:0] len_end;

  always_comb begin
    if (word.start_search) begin
      eff_phase = PH_CODE;
      eff_first = 1'b1;
      eff_code  = 8'd0;
      eff_skip  = 8'd0;
      eff_pos   = '0;
    end else begin
      eff_phase = phase_r;
      eff_first = first_r;
      eff_code  = code_r;
      eff_skip  = skip_r;
      eff_pos   = pos_r;
    end
    pos_adv = (eff_pos < POS_W'(MAX_AREA_BYTES - 1)) ? eff_pos + POS_W'(1) : eff_pos;
    len_end = LEFT_W'(word.data_byte) + LEFT_W'(1);

    phase_nxt = eff_phase;
    first_nxt = eff_first;
    code_nxt  = eff_code;
    skip_nxt  = eff_skip;
    pos_nxt   = eff_pos;
    res       = '0;

    case (eff_phase)
      PH_CODE: begin
        if (word.bytes_left < LEAST_ENTRY ||
            (!eff_first && (word.data_byte == PAD_CODE || word.data_byte == END_CODE))) begin
          res.valid = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          first_nxt = 1'b0;
          code_nxt  = word.data_byte;
          phase_nxt = PH_LEN;
          pos_nxt   = pos_adv;
        end
      end
      PH_LEN: begin
        if (eff_code == cfg.target_code && word.data_byte >= cfg.min_length) begin
          res.valid              = 1'b1;
          res.word.found         = 1'b1;
          res.word.value_length  = word.data_byte;
          res.word.value_offset  = OFFSET_W'({1'b0, eff_pos} + (POS_W + 1)'(1));
          phase_nxt              = PH_IDLE;
        end else if (len_end >= word.bytes_left) begin
          res.valid = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          skip_nxt  = word.data_byte;
          phase_nxt = (word.data_byte == 8'd0) ? PH_CODE : PH_SKIP;
          pos_nxt   = pos_adv;
        end
      end
      PH_SKIP: begin
        skip_nxt  = eff_skip - 8'd1;
        phase_nxt = (skip_nxt == 8'd0) ? PH_CODE : PH_SKIP;
        pos_nxt   = pos_adv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= 1'b1;
      code_r  <= 8'd0;
      skip_r  <= 8'd0;
      pos_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      code_r  <= code_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != 8'd0)
    else $error("skip phase with zero count");

  a_miss_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && !res.word.found |-> res.word.value_length == 8'd0 &&
                                     res.word.value_offset == '0)
    else $error("not-found result carries data");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.valid |=> phase_r == PH_IDLE)
    else $error("search still running after its result");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE && !word.start_search |-> !res.valid)
    else $error("result while idle");

endmodule

// ===== rtl/core/tos_out_reg.sv =====
// Result register feeding the out channel.
module tos_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  tos_pkg::scan_res_t  res,
  input  logic                out_stall,
  output logic                out_valid,
  output tos_pkg::out_word_t  out_word
);
  import tos_pkg::*;

  logic      valid_r;
  out_word_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire && res.valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      word_r <= res.word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/core/tlv_option_search_top.sv =====
// Top level of the option area search block: input register, walker, result register.
// Takes one option-area byte per cycle unless stalled and gives at most one word per
// search (found, value length, value offset). A byte is held in the input register and is
// judged as it moves on; a result enters the result register as its byte leaves the
// input register. The walker state register holds the only loop, one byte per cycle
// unless stalled; a stalled result holds the input register's byte and stalls the in side.
module tlv_option_search_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tos_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tos_pkg::out_word_t          out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tos_pkg::PADDR_W-1:0] paddr,
  input  logic [tos_pkg::PDATA_W-1:0] pwdata,
  output logic [tos_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tos_pkg::*;

  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      fire;
  cfg_t      cfg;
  scan_res_t res;

  assign fire     = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
  end

  tos_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tos_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (in_word_r),
    .cfg   (cfg),
    .res   (res)
  );

  tos_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for tlv_option_search_top: option areas are streamed in and checked against a predictor.
module tb;
  import tos_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 60;

  typedef enum logic [1:0] {WALK_IDLE, WALK_CODE, WALK_LEN, WALK_SKIP} walk_phase_t;
  typedef logic [7:0] byte_q_t[$];

  class option_scoreboard;
    logic [7:0]       target_code;
    logic [7:0]       min_length;
    walk_phase_t      phase;
    bit               first_entry;
    logic [7:0]       entry_code;
    logic [7:0]       skip_count;
    logic [POS_W-1:0] byte_pos;
    out_word_t        search_results[$];
    int               errors;

    function new();
      target_code = 8'h00;
      min_length  = 8'h01;
      phase       = WALK_IDLE;
      first_entry = 1'b1;
      entry_code  = 8'h00;
      skip_count  = 8'h00;
      byte_pos    = '0;
      errors      = 0;
    endfunction

    function void advance_position();
      if (byte_pos < POS_W'(MAX_AREA_BYTES - 1)) byte_pos++;
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      bit        done;
      r = '0;
      done = 1'b0;
      if (w.start_search) begin
        phase       = WALK_CODE;
        first_entry = 1'b1;
        entry_code  = 8'h00;
        skip_count  = 8'h00;
        byte_pos    = '0;
      end
      case (phase)
        WALK_CODE: begin
          if (w.bytes_left < LEAST_ENTRY) begin
            done = 1'b1;
          end else if (!first_entry && (w.data_byte == PAD_CODE || w.data_byte == END_CODE)) begin
            done = 1'b1;
          end else begin
            first_entry = 1'b0;
            entry_code  = w.data_byte;
            phase       = WALK_LEN;
            advance_position();
          end
        end
        WALK_LEN: begin
          if (entry_code == target_code && w.data_byte >= min_length) begin
            done = 1'b1;
            r.found        = 1'b1;
            r.value_length = w.data_byte;
            r.value_offset = OFFSET_W'(byte_pos + POS_W'(1));
          end else if (int'(w.data_byte) + 1 >= int'(w.bytes_left)) begin
            done = 1'b1;
          end else begin
            skip_count = w.data_byte;
            phase      = (w.data_byte == 8'h00) ? WALK_CODE : WALK_SKIP;
            advance_position();
          end
        end
        WALK_SKIP: begin
          skip_count = skip_count - 8'h01;
          if (skip_count == 8'h00) phase = WALK_CODE;
          advance_position();
        end
        default: ;
      endcase
      if (done) begin
        phase = WALK_IDLE;
        search_results.push_back(r);
      end
    endfunction

    function void note_error(string what, out_word_t want, out_word_t got);
      errors++;
      if (errors <= 10)
        $display("%0t %s: got found=%0b len=%0d off=%0d, expected found=%0b len=%0d off=%0d",
                 $time, what, got.found, got.value_length, got.value_offset,
                 want.found, want.value_length, want.value_offset);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (search_results.size() == 0) begin
        note_error("unexpected word", '0, got);
        return;
      end
      want = search_results.pop_front();
      if (got.found !== want.found || got.value_length !== want.value_length ||
          got.value_offset !== want.value_offset)
        note_error("mismatch", want, got);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  bit                  calm;
  int                  cycles = 0;
  option_scoreboard    board;

  tlv_option_search_top uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 16);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_input(in_word);
      if (out_valid && !out_stall) board.check_result(out_word);
    end
  end

  task automatic send_word(input logic [7:0] data, input logic [LEFT_W-1:0] left,
                           input logic start);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 16) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: data, bytes_left: left, start_search: start};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_run(input byte_q_t bytes, input int first_left);
    foreach (bytes[i]) send_word(bytes[i], LEFT_W'(first_left - i), i == 0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.search_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MIN_LENGTH) board.min_length = value;
    else board.target_code = value;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code(bit first);
    int r;
    r = $urandom_range(99);
    if (r < 30) return board.target_code;
    if (first && r < 38) return PAD_CODE;
    if (first && r < 44) return END_CODE;
    return 8'($urandom_range(1, 254));
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'($urandom_range(0, 6));
    if (r < 98) return 8'($urandom_range(7, 30));
    return 8'($urandom_range(31, 255));
  endfunction

  task automatic send_random_area(output int counted);
    byte_q_t    bytes;
    logic [7:0] code;
    logic [7:0] len;
    int         mode;
    int         n;
    int         keep;
    bit         matched;
    mode    = $urandom_range(99);
    matched = 1'b0;
    counted = 0;
    if (mode < 70) begin
      n = $urandom_range(1, 5);
      for (int e = 0; e < n && !matched; e++) begin
        code = pick_code(e == 0);
        len  = pick_len();
        if (code == board.target_code) begin
          case ($urandom_range(3))
            0: len = board.min_length;
            1: len = board.min_length - 8'h01;
            default: ;
          endcase
        end
        matched = (code == board.target_code) && (len >= board.min_length);
        bytes.push_back(code);
        bytes.push_back(len);
        keep = matched ? $urandom_range(0, (len < 4) ? len : 4) : len;
        repeat (keep) bytes.push_back(8'($urandom));
      end
      if (!matched) begin
        case ($urandom_range(9))
          0, 1, 2, 3: bytes.push_back(END_CODE);
          4: repeat ($urandom_range(1, 3)) bytes.push_back(PAD_CODE);
          5: repeat ($urandom_range(1, 3)) if (bytes.size() > 1) void'(bytes.pop_back());
          default: ;
        endcase
      end
      send_run(bytes, bytes.size());
      counted = bytes.size();
    end else if (mode < 85) begin
      n = $urandom_range(1, 12);
      repeat (n) bytes.push_back(8'($urandom));
      send_run(bytes, n);
      counted = n;
    end else if (mode < 95) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_word(8'($urandom), LEFT_W'($urandom_range(0, 2047)),
                  i == 0 || $urandom_range(9) == 0);
      counted = n;
    end else if (mode < 98) begin
      // abandon this area midway; the next start cuts it off
      bytes.push_back(8'($urandom_range(1, 254)));
      bytes.push_back(8'($urandom_range(3, 20)));
      repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
      send_run(bytes, bytes.size() + $urandom_range(5, 40));
      counted = bytes.size();
    end else begin
      n = $urandom_range(1, 3);
      repeat (n)
        send_word(8'($urandom), LEFT_W'($urandom_range(0, 2047)), 1'b0);
      counted = n;
    end
  endtask

  initial begin
    byte_q_t    area;
    int         sent;
    int         n;
    bit         paused;
    logic [7:0] t;
    logic [7:0] m;
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    calm      = 1'b0;
    paused    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_run('{8'h00, 8'h01, 8'hAA}, 3);
    drain_results();
    reg_write(REG_TARGET_CODE, 8'h35);
    reg_write(REG_MIN_LENGTH, 8'h02);
    send_run('{8'h35, 8'h02, 8'hFF, 8'h00}, 4);
    send_run('{8'h35}, 2);
    send_run('{8'h35, 8'h01, 8'h7E, 8'h35, 8'h03, 8'h5A}, 6);
    send_run('{8'h10, 8'h00, 8'hFF}, 5);
    send_run('{8'hFF, 8'h00, 8'h00}, 9);
    send_run('{8'h10, 8'h05, 8'h01}, 10);
    send_run('{8'h35, 8'hFF}, 3);
    send_run('{8'h20, 8'h03, 8'h00}, 4);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin t = 8'h00; m = 8'h00; end
        1: begin t = 8'hFF; m = 8'hFF; end
        2: begin t = 8'hFF; m = 8'h00; end
        3: begin t = 8'h00; m = 8'hFF; end
        4: begin t = 8'h42; m = 8'h00; end
        default: begin
          t = 8'($urandom);
          m = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        end
      endcase
      reg_write(REG_TARGET_CODE, t);
      reg_write(REG_MIN_LENGTH, m);
      calm = (p == 5);
      sent = 0;
      if (p == 4) begin
        // long area: skip a full-length entry before the match
        area.delete();
        area.push_back(8'h01);
        area.push_back(8'hFF);
        repeat (255) area.push_back(8'($urandom));
        area.push_back(8'h42);
        area.push_back(8'h07);
        repeat (3) area.push_back(8'($urandom));
        send_run(area, area.size());
        sent = area.size();
      end
      while (sent < PHASE_ITEMS) begin
        if (p == 6 && !paused && sent >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        send_random_area(n);
        sent += n;
      end
    end
    calm = 1'b0;
    drain_results();
    board.errors += board.search_results.size();
    if (board.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ===== tlv_option_search_top.f =====
rtl/core/tos_pkg.sv
rtl/core/tos_cfg_regs.sv
rtl/core/tos_scan.sv
rtl/core/tos_out_reg.sv
rtl/core/tlv_option_search_top.sv
tb/tb.sv
